// ===== design/jlac_pkg.sv =====
package jlac_pkg;

  localparam int NUM_PFX = 7;
  localparam int PFX_MAX = 15;

  // Input action codes.
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // Result kind codes.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  // Segment codes.
  localparam logic SEG_HEADER  = 1'b0;
  localparam logic SEG_MESSAGE = 1'b1;

  // Line type codes.
  localparam logic [2:0] LT_HEADER   = 3'd0;
  localparam logic [2:0] LT_STANDARD = 3'd1;
  localparam logic [2:0] LT_BOLD     = 3'd2;
  localparam logic [2:0] LT_ERROR    = 3'd3;
  localparam logic [2:0] LT_WARNING  = 3'd4;
  localparam logic [2:0] LT_DEBUG    = 3'd5;
  localparam logic [2:0] LT_AUDIT    = 3'd6;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CSI_LO   = 8'h40;
  localparam logic [7:0] CSI_HI   = 8'h7E;

  localparam logic [4:0] POS_MAX = 5'd31;

  typedef enum logic [1:0] {
    ESC_PLAIN = 2'd0,
    ESC_AFTER = 2'd1,
    ESC_CSI   = 2'd2
  } esc_phase_t;

  typedef struct packed {
    logic       kind;
    logic       segment;
    logic [7:0] out_byte;
    logic [2:0] line_type;
    logic       line_last;
  } jlac_result_t;

  // Colour prefixes; entries past a prefix's length are never compared.
  localparam logic [7:0] PFX_TEXT [NUM_PFX][PFX_MAX] = '{
    '{8'h1B, "[", "0", ";", "1", ";", "3", "9", "m",
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h1B, "[", "0", ";", "1", ";", "3", "1", "m",
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h1B, "[", "0", ";", "1", ";", "3", "8", ";", "5", ";", "1", "8", "5", "m"},
    '{8'h1B, "[", "0", ";", "1", ";", "3", "8", ":", "5", ":", "1", "8", "5", "m"},
    '{8'h1B, "[", "0", ";", "3", "8", ";", "5", ";", "2", "4", "5", "m",
      8'h00, 8'h00},
    '{8'h1B, "[", "0", ";", "3", "8", ":", "5", ":", "2", "4", "5", "m",
      8'h00, 8'h00},
    '{8'h1B, "[", "0", ";", "3", "4", "m",
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [4:0] PFX_LEN [NUM_PFX] = '{5'd9, 5'd9, 5'd15, 5'd15, 5'd13, 5'd13, 5'd7};

  localparam logic [2:0] PFX_TYPE [NUM_PFX] = '{
    LT_BOLD, LT_ERROR, LT_WARNING, LT_WARNING, LT_DEBUG, LT_DEBUG, LT_AUDIT
  };

endpackage

// ===== design/jlac_line_fsm.sv =====
module jlac_line_fsm
  import jlac_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         take,
  input  logic         action,
  input  logic [7:0]   char_value,
  output logic         res_valid,
  output jlac_result_t res
);

  logic                 line_has_bytes, line_has_bytes_next;
  logic                 colon_pending, colon_pending_next;
  logic                 in_message, in_message_next;
  logic [4:0]           message_position, message_position_next;
  logic [NUM_PFX-1:0]   prefix_match_bits, prefix_match_bits_next;
  logic                 strip_mode, strip_mode_next;
  esc_phase_t           escape_phase, escape_phase_next;

  logic                 close_req;
  logic                 strip_eff;
  logic [2:0]           kind_of_line;

  // Line type from the state of the line being closed.
  always_comb begin
    kind_of_line = LT_STANDARD;
    if (!in_message) begin
      kind_of_line = LT_HEADER;
    end else if (strip_mode) begin
      for (int i = NUM_PFX - 1; i >= 0; i--) begin
        if (prefix_match_bits[i] && (message_position >= PFX_LEN[i])) begin
          kind_of_line = PFX_TYPE[i];
        end
      end
    end
  end

  assign close_req = (action == ACT_END) || (char_value == CH_LF);
  assign strip_eff = (message_position == 5'd0) ? (char_value == CH_ESC) : strip_mode;

  always_comb begin
    line_has_bytes_next    = line_has_bytes;
    colon_pending_next     = colon_pending;
    in_message_next        = in_message;
    message_position_next  = message_position;
    prefix_match_bits_next = prefix_match_bits;
    strip_mode_next        = strip_mode;
    escape_phase_next      = escape_phase;
    res_valid              = 1'b0;
    res.kind               = KIND_BYTE;
    res.segment            = SEG_HEADER;
    res.out_byte           = char_value;
    res.line_type          = LT_HEADER;
    res.line_last          = 1'b0;

    if (close_req) begin
      if (line_has_bytes) begin
        res_valid              = 1'b1;
        res.kind               = KIND_EOL;
        res.segment            = in_message ? SEG_MESSAGE : SEG_HEADER;
        res.out_byte           = 8'h00;
        res.line_type          = kind_of_line;
        res.line_last          = 1'b1;
        line_has_bytes_next    = 1'b0;
        colon_pending_next     = 1'b0;
        in_message_next        = 1'b0;
        message_position_next  = 5'd0;
        prefix_match_bits_next = '1;
        strip_mode_next        = 1'b0;
        escape_phase_next      = ESC_PLAIN;
      end
    end else begin
      line_has_bytes_next = 1'b1;
      if (!in_message) begin
        if (colon_pending && (char_value == CH_SPACE)) begin
          colon_pending_next = 1'b0;
          in_message_next    = 1'b1;
        end else begin
          colon_pending_next = (char_value == CH_COLON);
          res_valid          = 1'b1;
        end
      end else begin
        strip_mode_next = strip_eff;
        for (int i = 0; i < NUM_PFX; i++) begin
          if ((message_position < PFX_LEN[i]) &&
              (PFX_TEXT[i][message_position[3:0]] != char_value)) begin
            prefix_match_bits_next[i] = 1'b0;
          end
        end
        if (message_position != POS_MAX) begin
          message_position_next = message_position + 5'd1;
        end
        res.segment = SEG_MESSAGE;
        if (!strip_eff) begin
          res_valid = 1'b1;
        end else begin
          unique case (escape_phase)
            ESC_AFTER: begin
              escape_phase_next = (char_value == CH_LBRK) ? ESC_CSI : ESC_PLAIN;
            end
            ESC_CSI: begin
              if ((char_value >= CSI_LO) && (char_value <= CSI_HI)) begin
                escape_phase_next = ESC_PLAIN;
              end
            end
            default: begin
              escape_phase_next = ESC_PLAIN;
              if (char_value == CH_ESC) begin
                escape_phase_next = ESC_AFTER;
              end else if ((char_value >= CH_SPACE) || (char_value == CH_TAB)) begin
                res_valid = 1'b1;
              end
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_has_bytes    <= 1'b0;
      colon_pending     <= 1'b0;
      in_message        <= 1'b0;
      message_position  <= 5'd0;
      prefix_match_bits <= '1;
      strip_mode        <= 1'b0;
      escape_phase      <= ESC_PLAIN;
    end else if (take) begin
      line_has_bytes    <= line_has_bytes_next;
      colon_pending     <= colon_pending_next;
      in_message        <= in_message_next;
      message_position  <= message_position_next;
      prefix_match_bits <= prefix_match_bits_next;
      strip_mode        <= strip_mode_next;
      escape_phase      <= escape_phase_next;
    end
  end

  a_strip_in_msg: assert property (@(posedge clk) disable iff (rst)
    strip_mode |-> in_message)
    else $error("strip mode set outside a message");

  a_pos_in_msg: assert property (@(posedge clk) disable iff (rst)
    (message_position != 5'd0) |-> in_message)
    else $error("message position advanced outside a message");

  a_esc_needs_strip: assert property (@(posedge clk) disable iff (rst)
    (escape_phase != ESC_PLAIN) |-> strip_mode)
    else $error("escape phase active on a raw message");

  a_msg_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (in_message || colon_pending) |-> line_has_bytes)
    else $error("line state set on an empty line");

  a_header_eol: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == KIND_EOL && res.segment == SEG_HEADER)
      |-> (res.line_type == LT_HEADER))
    else $error("line without separator typed as message");

endmodule

// ===== design/jlac_out_reg.sv =====
module jlac_out_reg
  import jlac_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         take,
  input  logic         res_valid,
  input  jlac_result_t res,
  output logic         can_take,
  input  logic         out_ready,
  output logic         out_valid,
  output jlac_result_t out_res
);

  logic out_valid_next;

  assign can_take = !out_valid || out_ready;

  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    if (take && res_valid) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      out_res <= res;
    end
  end

endmodule

// ===== design/journal_line_ansi_classifier.sv =====
// Journal line classifier: takes one Latin-1 byte (or an end-of-text flush) per
// transfer and splits the stream into lines at newline, skipping empty lines.
// Bytes up to and including the first colon followed by a space come out as
// header text (segment 0), the space itself is dropped, and the rest of the
// line is the message (segment 1). A message starting with ESC has its ANSI
// escape sequences and control bytes other than tab removed, and its opening
// colour sequence sets the line type; a plain message is passed raw and typed
// standard, and a line with no separator is typed header. Closing a line
// yields one end-of-line item with line_last set and the line type.
// Throughput is one input transfer per clock cycle unless the output stalls:
// each byte is decoded by combinational logic and its result, if any, is
// written into a one-entry output register. in_ready is high whenever that
// register is empty or is being drained in the same cycle, so the output
// register alone sets the rate under back-pressure.
module journal_line_ansi_classifier
  import jlac_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       action,
  input  logic [7:0] char_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       kind,
  output logic       segment,
  output logic [7:0] out_byte,
  output logic [2:0] line_type,
  output logic       line_last
);

  logic         take;
  logic         res_valid;
  jlac_result_t res;
  jlac_result_t out_res;

  // A transfer is taken whenever the output register has room for its result.
  assign take = in_valid && in_ready;

  jlac_line_fsm u_line (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .action     (action),
    .char_value (char_value),
    .res_valid  (res_valid),
    .res        (res)
  );

  jlac_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .res_valid (res_valid),
    .res       (res),
    .can_take  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign kind      = out_res.kind;
  assign segment   = out_res.segment;
  assign out_byte  = out_res.out_byte;
  assign line_type = out_res.line_type;
  assign line_last = out_res.line_last;

endmodule
